@@ sv/sds_pkg.sv @@
`default_nettype none

package sds_pkg;

	// Delimiter sizing
	localparam int MAX_DELIM  = 8;
	localparam int LEN_W      = $clog2(MAX_DELIM + 1);
	localparam int HOLD_DEPTH = MAX_DELIM - 1;
	localparam int FILL_W     = $clog2(MAX_DELIM);
	localparam int DELIM_REG_BYTES = 8;
	localparam int DELIM_REG_W     = 8 * DELIM_REG_BYTES;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = DELIM_REG_W;
	localparam logic [CFG_IDX_W-1:0] CFG_DELIM_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DELIM_BYTES  = 1'd1;
	localparam logic [LEN_W-1:0]       DELIM_LENGTH_RST = LEN_W'(2);
	localparam logic [DELIM_REG_W-1:0] DELIM_BYTES_RST  = DELIM_REG_W'(64'h0A0D);

	// Input commands
	localparam logic [1:0] CMD_DATA = 2'd0;
	localparam logic [1:0] CMD_EOS  = 2'd1;
	localparam logic [1:0] CMD_ERR  = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_DATA  = 2'd0;
	localparam logic [1:0] ST_DELIM = 2'd1;
	localparam logic [1:0] ST_EOS   = 2'd2;
	localparam logic [1:0] ST_ERR   = 2'd3;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] in_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] out_status;
		logic       out_last;
	} out_item_t;

	// Item class decided in the front
	typedef enum logic [1:0] {
		KIND_DATA,
		KIND_EOS,
		KIND_ERR
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} q_entry_t;

endpackage

`default_nettype wire

@@ sv/sds_front.sv @@
`default_nettype none

// Input register; classifies each item before it goes into the queue.
module sds_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire sds_pkg::in_item_t in_item,
	output logic                   push,
	output sds_pkg::q_entry_t      push_entry,
	input  wire logic              q_full
);

	logic              valid_s1;
	sds_pkg::q_entry_t entry_s1;
	sds_pkg::kind_t    kind;
	logic              load;

	// Unused command code counts as a read error
	always_comb begin
		if (in_item.cmd == sds_pkg::CMD_DATA) begin
			kind = sds_pkg::KIND_DATA;
		end else if (in_item.cmd == sds_pkg::CMD_EOS) begin
			kind = sds_pkg::KIND_EOS;
		end else begin
			kind = sds_pkg::KIND_ERR;
		end
	end

	assign push       = valid_s1 && !q_full;
	assign in_stall   = valid_s1 && q_full;
	assign load       = in_valid && !in_stall;
	assign push_entry = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			entry_s1.kind <= kind;
			entry_s1.data <= in_item.in_byte;
		end
	end

	// Stage holds while the queue is full
	a_hold_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && q_full |=> valid_s1 && $stable(entry_s1))
		else $error("front stage lost an item while queue full");
	a_no_push_empty: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> valid_s1)
		else $error("push without a held item");
	a_stall_means_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && !push)
		else $error("stall while able to move");

endmodule

`default_nettype wire

@@ sv/sds_queue.sv @@
`default_nettype none

// Small queue decoupling the front from the back.
module sds_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire sds_pkg::q_entry_t push_entry,
	output logic                   full,
	input  wire logic              pop,
	output logic                   not_empty,
	output sds_pkg::q_entry_t      head
);

	sds_pkg::q_entry_t                mem_q [sds_pkg::QUEUE_DEPTH];
	logic [sds_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [sds_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [sds_pkg::QCNT_W-1:0]       count_q;

	assign full      = (count_q == sds_pkg::QCNT_W'(sds_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue pop while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= sds_pkg::QCNT_W'(sds_pkg::QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

`default_nettype wire

@@ sv/sds_back.sv @@
`default_nettype none

// Delimiter matcher, holdback line and output register.
module sds_back (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [sds_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [sds_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            q_not_empty,
	input  wire sds_pkg::q_entry_t               q_head,
	output logic                                 pop,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output sds_pkg::out_item_t                   out_item
);

	logic [sds_pkg::LEN_W-1:0]       delim_length_q;
	logic [sds_pkg::DELIM_REG_W-1:0] delim_bytes_q;
	logic [sds_pkg::MAX_DELIM-1:0]   match_q;
	logic [7:0]                      hold_line_q [sds_pkg::HOLD_DEPTH];
	logic [sds_pkg::FILL_W-1:0]      fill_q;
	logic                            out_valid_q;
	sds_pkg::out_item_t              out_item_q;

	logic [sds_pkg::LEN_W-1:0]       len_eff;
	logic [sds_pkg::LEN_W-1:0]       hold_m;
	logic [sds_pkg::FILL_W-1:0]      hold;
	logic [sds_pkg::MAX_DELIM-1:0]   eq;
	logic [sds_pkg::MAX_DELIM-1:0]   adv;
	logic [sds_pkg::MAX_DELIM-1:0]   match_nxt;
	logic                            done;
	logic                            advance;
	logic                            is_data;
	logic                            clear;
	logic                            has_result;
	sds_pkg::out_item_t              result;

	// Effective length: zero counts as one, saturate at the maximum
	always_comb begin
		if (delim_length_q == '0) begin
			len_eff = sds_pkg::LEN_W'(1);
		end else if (delim_length_q > sds_pkg::LEN_W'(sds_pkg::MAX_DELIM)) begin
			len_eff = sds_pkg::LEN_W'(sds_pkg::MAX_DELIM);
		end else begin
			len_eff = delim_length_q;
		end
	end
	assign hold_m = len_eff - sds_pkg::LEN_W'(1);
	assign hold   = hold_m[sds_pkg::FILL_W-1:0];

	// Shift-and match update; positions past the register read as zero
	always_comb begin
		for (int i = 0; i < sds_pkg::MAX_DELIM; i++) begin
			if (i < sds_pkg::DELIM_REG_BYTES) begin
				eq[i] = (q_head.data == delim_bytes_q[8*i +: 8]);
			end else begin
				eq[i] = (q_head.data == 8'd0);
			end
		end
		adv[0] = eq[0];
		for (int i = 1; i < sds_pkg::MAX_DELIM; i++) begin
			adv[i] = match_q[i-1] && eq[i];
		end
		for (int i = 0; i < sds_pkg::MAX_DELIM; i++) begin
			match_nxt[i] = adv[i] && (sds_pkg::LEN_W'(i) < len_eff);
		end
	end
	assign done = adv[hold];

	assign advance = !out_valid_q || !out_stall;
	assign pop     = q_not_empty && advance;
	assign is_data = (q_head.kind == sds_pkg::KIND_DATA);
	assign clear   = pop && (!is_data || done);

	// Result selection for the item at the queue head
	always_comb begin
		result     = '0;
		has_result = 1'b0;
		unique case (q_head.kind)
			sds_pkg::KIND_DATA: begin
				if (done) begin
					has_result        = 1'b1;
					result.out_status = sds_pkg::ST_DELIM;
					result.out_last   = 1'b1;
				end else if (hold == '0) begin
					has_result        = 1'b1;
					result.out_byte   = q_head.data;
					result.out_status = sds_pkg::ST_DATA;
				end else if (fill_q >= hold) begin
					has_result        = 1'b1;
					result.out_byte   = hold_line_q[0];
					result.out_status = sds_pkg::ST_DATA;
				end
			end
			sds_pkg::KIND_EOS: begin
				has_result        = 1'b1;
				result.out_status = sds_pkg::ST_EOS;
				result.out_last   = 1'b1;
			end
			sds_pkg::KIND_ERR: begin
				has_result        = 1'b1;
				result.out_status = sds_pkg::ST_ERR;
				result.out_last   = 1'b1;
			end
			default: begin
				has_result        = 1'b1;
				result.out_status = sds_pkg::ST_ERR;
				result.out_last   = 1'b1;
			end
		endcase
	end

	// Configuration registers and record state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_length_q <= sds_pkg::DELIM_LENGTH_RST;
			delim_bytes_q  <= sds_pkg::DELIM_BYTES_RST;
			match_q        <= '0;
			fill_q         <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sds_pkg::CFG_DELIM_LENGTH: begin
					delim_length_q <= cfg_data[sds_pkg::LEN_W-1:0];
				end
				sds_pkg::CFG_DELIM_BYTES: begin
					delim_bytes_q <= cfg_data[sds_pkg::DELIM_REG_W-1:0];
				end
				default: begin
				end
			endcase
			match_q <= '0;
			fill_q  <= '0;
		end else if (clear) begin
			match_q <= '0;
			fill_q  <= '0;
		end else if (pop) begin
			match_q <= match_nxt;
			if (hold != '0 && fill_q < hold) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// Holdback line: fill at the count, then shift with the new byte at the end
	always_ff @(posedge clk) begin
		if (pop && is_data && !done && hold != '0) begin
			for (int i = 0; i < sds_pkg::HOLD_DEPTH; i++) begin
				if (fill_q < hold) begin
					if (sds_pkg::FILL_W'(i) == fill_q) begin
						hold_line_q[i] <= q_head.data;
					end
				end else if (sds_pkg::FILL_W'(i) == hold - 1'b1) begin
					hold_line_q[i] <= q_head.data;
				end else if (sds_pkg::FILL_W'(i) < hold - 1'b1) begin
					hold_line_q[i] <= hold_line_q[(i + 1) % sds_pkg::HOLD_DEPTH];
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= pop && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && has_result) begin
			out_item_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= hold)
		else $error("holdback fill exceeds delimiter length");
	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> fill_q == '0 && match_q == '0)
		else $error("configuration write did not clear the record");
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_item_q.out_status != sds_pkg::ST_DATA |-> out_item_q.out_last)
		else $error("record end without last");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !(out_valid_q && out_stall))
		else $error("queue pop while result is stalled");

endmodule

`default_nettype wire

@@ sv/stream_delimiter_splitter.sv @@
`default_nettype none

// Splits a byte stream into records ended by a delimiter of 1 to 8 bytes (reset: CR LF).
// One item is taken per cycle while in_stall is low; a result reaches the output through
// the input register, the four-entry queue and the output register.
// Data bytes come out delayed by length-1 bytes, since the last length-1 bytes of a record
// sit in the holdback line until they are known not to begin the delimiter; the delimiter
// itself is never passed on. A completed delimiter, end of stream or read error each produce
// one result with out_last set and start a fresh record. Write the configuration only
// while the block is idle; a write also drops any held bytes.
module stream_delimiter_splitter (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire sds_pkg::in_item_t              in_item,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output sds_pkg::out_item_t                  out_item,
	input  wire logic                           cfg_we,
	input  wire logic [sds_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [sds_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic              push;
	sds_pkg::q_entry_t push_entry;
	logic              q_full;
	logic              pop;
	logic              q_not_empty;
	sds_pkg::q_entry_t q_head;

	sds_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full)
	);

	sds_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.not_empty  (q_not_empty),
		.head       (q_head)
	);

	sds_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_item    (out_item)
	);

endmodule

`default_nettype wire
